// File: hdl/wrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg: shared constants of the weighted random switch
// Field widths, trigger thresholds and register reset value.
// ----------------------------------------------------------------------------
package wrs_pkg;

   // field widths
   localparam int SAMPLE_W = 15;
   localparam int RND_W    = 16;
   localparam int WEIGHT_W = 8;
   localparam int SEL_W    = 3;
   localparam int CSR_W    = 32;

   // schmitt trigger thresholds in mV
   localparam logic signed [SAMPLE_W-1:0] TRIG_HIGH_MV = 15'sd2000;
   localparam logic signed [SAMPLE_W-1:0] TRIG_LOW_MV  = 15'sd100;

   // weight after reset
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd128;

   // log2 of the byte distance between registers on the config port
   localparam int CSR_ADDR_LSB = 2;

endpackage

// File: hdl/weighted_random_switch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_switch_unit: weighted random channel switch
// Schmitt trigger on the trigger level; each rising edge draws a channel with
// probability proportional to its weight and routes its sample to the output.
// ----------------------------------------------------------------------------
// Path: req word, input stage registers, output stage registers, rsp word.
// Throughput: one word per cycle unless rsp stalls; draw multiply in the
// input stage, lane compares, merge and sample select in the output stage.
// Reset: synchronous; weights return to 128, trigger low, channel 0 selected.
// No clearing pass: the block takes words in the cycle after reset.
// ----------------------------------------------------------------------------
module weighted_random_switch_unit #(
   parameter int CHANNELS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // input stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // trigger_mv, random_word, channel_0 .. channel_N-1, zero pad
   input  logic [((31 + 15 * CHANNELS + 7) / 8) * 8 - 1:0] req_tdata,
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_sample, selected_channel, new_pick, zero pad
   output logic [23:0]               rsp_tdata,
   // config port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [$clog2(CHANNELS)+1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int IDX_W  = $clog2(CHANNELS);
   localparam int SUM_W  = $clog2(CHANNELS * 255 + 1);
   localparam int PROD_W = wrs_pkg::RND_W + SUM_W;
   localparam int SMP_W  = wrs_pkg::SAMPLE_W;
   localparam int CH_LSB = SMP_W + wrs_pkg::RND_W;

   // config registers and running weight sums
   logic [wrs_pkg::WEIGHT_W-1:0] weight_ff [CHANNELS];
   logic [SUM_W-1:0]             prefix_ff [CHANNELS];
   logic [IDX_W-1:0]             csr_idx;
   logic                         csr_hit;
   logic                         csr_wr;
   logic [wrs_pkg::WEIGHT_W-1:0] csr_wval;
   logic [wrs_pkg::WEIGHT_W-1:0] csr_old;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[IDX_W+wrs_pkg::CSR_ADDR_LSB-1:wrs_pkg::CSR_ADDR_LSB];
   assign csr_hit    = 32'(csr_idx) < CHANNELS;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_wval   = csr_pwdata[wrs_pkg::WEIGHT_W-1:0];
   assign csr_old    = csr_hit ? weight_ff[csr_idx] : '0;
   assign csr_prdata = csr_hit ? 32'(weight_ff[csr_idx]) : '0;

   // a write moves every running sum at or above its lane by the difference
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CHANNELS; j++) begin
            weight_ff[j] <= wrs_pkg::WEIGHT_RESET;
            prefix_ff[j] <= SUM_W'((j + 1) * 128);
         end
      end else if (csr_wr) begin
         for (int j = 0; j < CHANNELS; j++) begin
            if (32'(csr_idx) == j) begin
               weight_ff[j] <= csr_wval;
            end
            if (32'(csr_idx) <= j) begin
               prefix_ff[j] <= prefix_ff[j] - SUM_W'(csr_old) + SUM_W'(csr_wval);
            end
         end
      end
   end

   // handshake control
   logic s1_v_ff, s1_v_in;
   logic out_v_ff, out_v_in;
   logic req_acc, out_load;

   assign out_load   = s1_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !s1_v_ff || out_load;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = out_v_ff;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (req_acc) begin
         s1_v_in = 1'b1;
      end else if (out_load) begin
         s1_v_in = 1'b0;
      end
      out_v_in = out_v_ff;
      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   // input stage: schmitt trigger and draw scaling
   logic signed [SMP_W-1:0]      trig;
   logic [wrs_pkg::RND_W-1:0]    rnd;
   logic [PROD_W-1:0]            prod;
   logic                         trig_high_ff, trig_high_in;
   logic                         edge_det;
   logic                         s1_edge_ff;
   logic [SUM_W-1:0]             s1_draw_ff;
   logic signed [SMP_W-1:0]      s1_samp_ff [CHANNELS];

   assign trig = $signed(req_tdata[SMP_W-1:0]);
   assign rnd  = req_tdata[CH_LSB-1:SMP_W];
   assign prod = PROD_W'(rnd) * PROD_W'(prefix_ff[CHANNELS-1]);

   always_comb begin
      trig_high_in = trig_high_ff;
      edge_det     = 1'b0;
      if (!trig_high_ff) begin
         if (trig >= wrs_pkg::TRIG_HIGH_MV) begin
            trig_high_in = 1'b1;
            edge_det     = 1'b1;
         end
      end else if (trig <= wrs_pkg::TRIG_LOW_MV) begin
         trig_high_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_high_ff <= 1'b0;
      end else if (req_acc) begin
         trig_high_ff <= trig_high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_edge_ff <= edge_det;
         s1_draw_ff <= prod[wrs_pkg::RND_W +: SUM_W];
         for (int i = 0; i < CHANNELS; i++) begin
            s1_samp_ff[i] <= $signed(req_tdata[CH_LSB + SMP_W * i +: SMP_W]);
         end
      end
   end

   // lanes compare the draw against each running sum
   logic [CHANNELS-1:0] hit;
   logic                found;
   logic [IDX_W-1:0]    pick_idx;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      wrs_lane #(
         .SUM_W(SUM_W)
      ) u_lane (
         .draw  (s1_draw_ff),
         .prefix(prefix_ff[g]),
         .weight(weight_ff[g]),
         .hit   (hit[g])
      );
   end

   wrs_merge #(
      .CHANNELS(CHANNELS)
   ) u_merge (
      .hit  (hit),
      .found(found),
      .index(pick_idx)
   );

   // output stage: channel update and sample routing
   logic [IDX_W-1:0]        chosen_ff, chosen_in;
   logic signed [SMP_W-1:0] out_sample_ff;
   logic [wrs_pkg::SEL_W-1:0] out_sel_ff;
   logic                    out_pick_ff;

   assign chosen_in = (s1_edge_ff && found) ? pick_idx : chosen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         chosen_ff <= '0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
         if (out_load) begin
            chosen_ff <= chosen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_sample_ff <= s1_samp_ff[chosen_in];
         out_sel_ff    <= wrs_pkg::SEL_W'(chosen_in);
         out_pick_ff   <= s1_edge_ff;
      end
   end

   assign rsp_tdata = {5'd0, out_pick_ff, out_sel_ff, out_sample_ff};

   // the selection moves only when an edge word enters the output stage
   assert property (@(posedge clock) disable iff (reset)
      (chosen_ff != $past(chosen_ff)) |-> $past(out_load && s1_edge_ff))
      else $error("selected channel changed without a trigger edge");

   // a nonzero weight total always yields a lane for the draw
   assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && (prefix_ff[CHANNELS-1] != '0)) |-> found)
      else $error("no lane claimed the draw");

   // the last running sum stays at or above the first
   assert property (@(posedge clock) disable iff (reset)
      prefix_ff[CHANNELS-1] >= prefix_ff[0])
      else $error("running weight sums out of order");

   // every word out reports the channel taken into the selection with it
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (out_sel_ff == wrs_pkg::SEL_W'(chosen_ff)))
      else $error("reported channel differs from selection");

endmodule

// File: hdl/wrs_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_lane: one channel lane of the roulette wheel
// Flags whether the draw falls below this channel's running weight sum.
// ----------------------------------------------------------------------------
module wrs_lane #(
   parameter int SUM_W = 12
) (
   input  logic [SUM_W-1:0] draw,
   input  logic [SUM_W-1:0] prefix,
   input  logic [wrs_pkg::WEIGHT_W-1:0] weight,
   output logic             hit
);

   // a lane with zero weight can never own the draw
   assign hit = (draw < prefix) && (weight != '0);

endmodule

// File: hdl/wrs_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_merge: merge of the lane results
// Priority encoder returning the lowest lane that claims the draw.
// ----------------------------------------------------------------------------
module wrs_merge #(
   parameter int CHANNELS = 8
) (
   input  logic [CHANNELS-1:0]         hit,
   output logic                        found,
   output logic [$clog2(CHANNELS)-1:0] index
);

   localparam int IDX_W = $clog2(CHANNELS);

   // lowest set lane wins
   always_comb begin
      index = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            index = IDX_W'(i);
         end
      end
   end

   assign found = |hit;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the weighted random switch
// Streams sample frames with trigger levels and random words through the
// unit, predicts the trigger edges, the channel draws and the routed sample,
// and checks every result word against that prediction. Weight registers go
// through several settings on the config port and are read back each time.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CHANNELS     = 8;
   localparam int REQ_W        = ((31 + wrs_pkg::SAMPLE_W * CHANNELS + 7) / 8) * 8;
   localparam int RSP_W        = 24;
   localparam int ADDR_W       = $clog2(CHANNELS) + 2;
   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 9;
   localparam int PIPE_LATENCY = 2;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 120;
   localparam int PHASE_WORDS  = 116;
   localparam int MAX_PRINTS   = 50;
   localparam int REG_WEIGHT_0 = 0;

   // weight patterns used by the random phases
   typedef enum int {
      MIX_RANDOM,
      MIX_FULL,
      MIX_SINGLE,
      MIX_SPARSE,
      MIX_LOW,
      MIX_COUNT
   } weight_mix_type;

   // one expected result word
   typedef struct {
      logic [wrs_pkg::SAMPLE_W-1:0] sample;
      logic [wrs_pkg::SEL_W-1:0]    chan;
      logic                         new_pick;
   } pick_type;

   // --------------------------------------------------------------------------
   // predictor and result store
   // --------------------------------------------------------------------------
   class channel_pick_board_type;
      logic [wrs_pkg::WEIGHT_W-1:0] weights [CHANNELS];
      bit                           trig_high;
      int unsigned                  chosen;
      pick_type                     pending_picks [$];
      int                           errors;
      int                           frames_seen;
      int                           results_seen;
      int                           edges_seen;

      function new();
         for (int i = 0; i < CHANNELS; i++) weights[i] = wrs_pkg::WEIGHT_RESET;
         trig_high    = 1'b0;
         chosen       = 0;
         errors       = 0;
         frames_seen  = 0;
         results_seen = 0;
         edges_seen   = 0;
      endfunction

      // register write as the unit sees it: upper bits dropped
      function void set_weight(int idx, logic [wrs_pkg::CSR_W-1:0] value);
         if (idx < CHANNELS) weights[idx] = value[wrs_pkg::WEIGHT_W-1:0];
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
         errors++;
      endtask

      // accepted input word: advance trigger and draw, queue the result
      function void take_frame(logic [REQ_W-1:0] word);
         logic signed [wrs_pkg::SAMPLE_W-1:0] level;
         logic [wrs_pkg::RND_W-1:0]           rnd;
         int unsigned                         total;
         int unsigned                         draw;
         int unsigned                         run;
         bit                                  rose;
         bit                                  found;
         pick_type                            p;
         level = word[wrs_pkg::SAMPLE_W-1:0];
         rnd   = word[wrs_pkg::SAMPLE_W +: wrs_pkg::RND_W];
         rose  = 1'b0;
         // schmitt trigger with hysteresis band
         if (!trig_high) begin
            if (level >= wrs_pkg::TRIG_HIGH_MV) begin
               trig_high = 1'b1;
               rose      = 1'b1;
            end
         end else if (level <= wrs_pkg::TRIG_LOW_MV) begin
            trig_high = 1'b0;
         end
         // roulette draw; all-zero weights keep the old channel
         if (rose) begin
            total = 0;
            for (int i = 0; i < CHANNELS; i++) total += weights[i];
            draw  = (32'(rnd) * total) >> wrs_pkg::RND_W;
            run   = 0;
            found = 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
               if (!found && draw < run + weights[i]) begin
                  chosen = i;
                  found  = 1'b1;
               end
               run += weights[i];
            end
            edges_seen++;
         end
         p.sample   = word[wrs_pkg::SAMPLE_W + wrs_pkg::RND_W + wrs_pkg::SAMPLE_W * chosen
                           +: wrs_pkg::SAMPLE_W];
         p.chan     = chosen[wrs_pkg::SEL_W-1:0];
         p.new_pick = rose;
         pending_picks.push_back(p);
         frames_seen++;
      endfunction

      // accepted result word against the oldest expectation
      task match_output(logic [RSP_W-1:0] word);
         pick_type want;
         results_seen++;
         if (pending_picks.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", word));
            return;
         end
         want = pending_picks.pop_front();
         if (word[wrs_pkg::SAMPLE_W-1:0] !== want.sample)
            report_mismatch($sformatf("out_sample got %0d want %0d",
               $signed(word[wrs_pkg::SAMPLE_W-1:0]), $signed(want.sample)));
         if (word[wrs_pkg::SAMPLE_W +: wrs_pkg::SEL_W] !== want.chan)
            report_mismatch($sformatf("selected_channel got %0d want %0d",
               word[wrs_pkg::SAMPLE_W +: wrs_pkg::SEL_W], want.chan));
         if (word[wrs_pkg::SAMPLE_W + wrs_pkg::SEL_W] !== want.new_pick)
            report_mismatch($sformatf("new_pick got %b want %b",
               word[wrs_pkg::SAMPLE_W + wrs_pkg::SEL_W], want.new_pick));
      endtask
   endclass

   // --------------------------------------------------------------------------
   // clock, signals, unit
   // --------------------------------------------------------------------------
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   // trigger_mv, random_word, channel_0 .. channel_7, zero pad
   logic [REQ_W-1:0]     req_tdata   = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   // out_sample, selected_channel, new_pick, zero pad
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]    csr_paddr   = '0;
   logic [31:0]          csr_pwdata  = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   bit                     gaps_on      = 1'b1;
   bit                     hold_request = 1'b0;
   channel_pick_board_type sb = new;

   always #CLK_HALF clock = ~clock;

   weighted_random_switch_unit #(.CHANNELS(CHANNELS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // --------------------------------------------------------------------------
   // monitor: both handshakes sampled at the rising edge
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.take_frame(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.match_output(rsp_tdata);
      end
   end

   // --------------------------------------------------------------------------
   // result side: random stall bursts and one long hold-off on request
   // --------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(7, 0) == 0) begin
            stall_left = $urandom_range(7, 1) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------------
   // watchdog: too long without any word moving
   // --------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("weighted_random_switch_unit verification failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------
   // register write, random junk in the upper bits half of the time
   task csr_write(int idx, logic [wrs_pkg::WEIGHT_W-1:0] w);
      logic [wrs_pkg::CSR_W-1:0] value;
      value = {($urandom_range(1, 0) ? 24'($urandom()) : 24'h0), w};
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'((REG_WEIGHT_0 + idx) << wrs_pkg::CSR_ADDR_LSB);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_weight(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task csr_read(int idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'((REG_WEIGHT_0 + idx) << wrs_pkg::CSR_ADDR_LSB);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {24'h0, sb.weights[idx]})
         sb.report_mismatch($sformatf("weight_%0d read %h want %h",
            idx, csr_prdata, sb.weights[idx]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one input word, with an optional idle burst ahead of it
   task send_frame(logic [wrs_pkg::SAMPLE_W-1:0] trig, logic [wrs_pkg::RND_W-1:0] rnd,
                   logic [wrs_pkg::SAMPLE_W*CHANNELS-1:0] samples);
      int gap;
      if (gaps_on && $urandom_range(5, 0) == 0) begin
         gap = $urandom_range(7, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({samples, rnd, trig});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and let every expected word come out
   task quiesce();
      req_tvalid <= 1'b0;
      while (sb.pending_picks.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   function automatic logic [wrs_pkg::SAMPLE_W*CHANNELS-1:0] rand_samples();
      logic [wrs_pkg::SAMPLE_W*CHANNELS-1:0] v;
      for (int i = 0; i < CHANNELS; i++)
         v[i*wrs_pkg::SAMPLE_W +: wrs_pkg::SAMPLE_W] = wrs_pkg::SAMPLE_W'($urandom());
      return v;
   endfunction

   // trigger levels biased toward clean high/low swings
   function automatic logic [wrs_pkg::SAMPLE_W-1:0] rand_trigger();
      int kind;
      int lvl;
      kind = $urandom_range(9, 0);
      if (kind <= 3) lvl = $urandom_range(12000, 2000);
      else if (kind <= 6) lvl = int'($urandom_range(12100, 0)) - 12000;
      else if (kind == 7) lvl = $urandom_range(1999, 101);
      else if (kind == 8)
         lvl = ($urandom_range(1, 0) ? 2000 : 100) + int'($urandom_range(2, 0)) - 1;
      else lvl = $urandom();
      return lvl[wrs_pkg::SAMPLE_W-1:0];
   endfunction

   task check_weights();
      for (int ch = 0; ch < CHANNELS; ch++) csr_read(ch);
   endtask

   task apply_mix(weight_mix_type mix);
      logic [wrs_pkg::WEIGHT_W-1:0] w;
      int                           lone;
      lone = $urandom_range(CHANNELS - 1, 0);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         case (mix)
            MIX_RANDOM: w = wrs_pkg::WEIGHT_W'($urandom());
            MIX_FULL:   w = 8'hff;
            MIX_SINGLE: w = (ch == lone) ? wrs_pkg::WEIGHT_W'($urandom_range(255, 1)) : '0;
            MIX_SPARSE: begin
               case ($urandom_range(3, 0))
                  0:       w = '0;
                  1:       w = 8'd1;
                  2:       w = 8'hff;
                  default: w = wrs_pkg::WEIGHT_W'($urandom());
               endcase
            end
            default:    w = wrs_pkg::WEIGHT_W'($urandom_range(3, 0));
         endcase
         csr_write(ch, w);
      end
      check_weights();
   endtask

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      logic [wrs_pkg::SAMPLE_W*CHANNELS-1:0] alt;
      alt = {(CHANNELS / 2){15'h3fff, 15'h4000}};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset weights, sum 1024: channel = random_word >> 13
      check_weights();
      send_frame(15'd0,     16'd0,      rand_samples());
      send_frame(15'd2000,  16'd0,      rand_samples());          // exact high threshold
      send_frame(15'h3fff,  16'hffff,   {CHANNELS{15'h3fff}});    // still high, no edge
      send_frame(15'd101,   16'd0,      rand_samples());          // band keeps high
      send_frame(15'd100,   16'd0,      rand_samples());          // exact low threshold
      send_frame(15'd1999,  16'hffff,   rand_samples());          // band keeps low
      send_frame(15'h3fff,  16'hffff,   rand_samples());          // top of the wheel
      send_frame(15'h4000,  16'd0,      {CHANNELS{15'h4000}});    // most negative level
      send_frame(15'd2000,  16'h8000,   rand_samples());
      send_frame(15'd100,   16'd0,      rand_samples());
      send_frame(15'd2001,  16'h1fff,   rand_samples());          // just under a slot edge
      send_frame(-15'sd12000, 16'd0,    rand_samples());
      send_frame(15'd12000, 16'h2000,   alt);                     // exactly on a slot edge
      send_frame(15'd99,    16'd0,      rand_samples());
      send_frame(15'd2000,  16'hdfff,   rand_samples());
      send_frame(15'd0,     16'd0,      rand_samples());
      quiesce();

      // all weights zero: edges still flagged, channel held
      for (int ch = 0; ch < CHANNELS; ch++) csr_write(ch, '0);
      check_weights();
      send_frame(15'd2000,  16'd12345,  rand_samples());
      send_frame(15'd50,    16'd0,      rand_samples());
      send_frame(15'h3fff,  16'hffff,   rand_samples());
      send_frame(15'h7fff,  16'd0,      rand_samples());
      quiesce();

      // random phases, one weight pattern each
      for (int p = 0; p < MIX_COUNT; p++) begin
         if (weight_mix_type'(p) == MIX_LOW) gaps_on = 1'b0;
         apply_mix(weight_mix_type'(p));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (weight_mix_type'(p) == MIX_FULL && n == 30) hold_request = 1'b1;
            if (weight_mix_type'(p) == MIX_SINGLE && n == 50) quiesce();
            send_frame(rand_trigger(), 16'($urandom()), rand_samples());
         end
         quiesce();
      end

      repeat (PIPE_LATENCY + 6) @(posedge clock);
      if (sb.pending_picks.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_picks.size()));
      $display("covered %0d input words, %0d results, %0d trigger edges, %0d weight sets",
         sb.frames_seen, sb.results_seen, sb.edges_seen, int'(MIX_COUNT) + 2);
      $display("with threshold and band levels, all-zero weights, result hold-off and read-back");
      if (sb.errors == 0) begin
         $display("weighted_random_switch_unit verification clean");
      end else begin
         $display("weighted_random_switch_unit verification failed");
      end
      $finish;
   end

endmodule

// File: weighted_random_switch_unit.f
hdl/wrs_pkg.sv
hdl/wrs_lane.sv
hdl/wrs_merge.sv
hdl/weighted_random_switch_unit.sv
bench/tb_top.sv
